[rtl/core/chcs_pkg.sv]
package chcs_pkg;

  // Number formats
  localparam int COORD_WIDTH = 16;                 // Q8.8 coordinates
  localparam int T_FRAC_BITS = 16;                 // t in Q1.16
  localparam int MAX_STEPS   = 63;
  localparam int GUARD_BITS  = 56 - COORD_WIDTH - T_FRAC_BITS;

  localparam int NUM_AXES  = 3;
  localparam int IN_W      = 4 * NUM_AXES * COORD_WIDTH;
  localparam int OUT_W     = NUM_AXES * COORD_WIDTH;

  // Step count register
  localparam int STEP_W     = 6;
  localparam int STEP_RESET = 32;

  // Datapath widths, sized from the coefficient bounds
  localparam int TW  = T_FRAC_BITS + 1;            // t, up to exactly one
  localparam int DW  = COORD_WIDTH + 1;            // point differences
  localparam int C3W = COORD_WIDTH + 4;            // cubic coefficient
  localparam int C2W = COORD_WIDTH + 5;            // square coefficient
  localparam int PRW = C3W + TW + 1;               // c3 * t
  localparam int B1W = C2W + T_FRAC_BITS + 1;      // first Horner step, guard/2^8
  localparam int M2W = B1W + TW + 1;               // b1 * t
  localparam int A2W = GUARD_BITS + C2W + 1;       // second Horner step
  localparam int M3W = A2W + TW + 1;               // a2 * t
  localparam int A3W = A2W + 1;                    // doubled curve, guard scaled
  localparam int RW  = A3W - GUARD_BITS - 1;       // rounded coordinate

  localparam int DIV_CNT_W = $clog2(TW);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [TW-1:0]                 tval_t;

  localparam logic signed [RW-1:0] SAT_HI = RW'((2 ** (COORD_WIDTH - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-(2 ** (COORD_WIDTH - 1)));

  localparam tval_t             T_ONE   = tval_t'(2 ** T_FRAC_BITS);
  localparam tval_t             Q_RESET = tval_t'((2 ** T_FRAC_BITS) / STEP_RESET);
  localparam logic [STEP_W-1:0] R_RESET = STEP_W'((2 ** T_FRAC_BITS) % STEP_RESET);

endpackage

[rtl/core/cubic_hermite_curve_sampler_unit.sv]
// Channel | Dir | Ports                          | Contents
// --------+-----+--------------------------------+------------------------------------------
// in      | in  | in_tvalid/in_tready/in_tdata   | four Q8.8 3D control points per item
// out     | out | out_tvalid/out_tready/         | one Q8.8 3D curve sample per transfer,
//         |     | out_tdata/out_tlast            | tlast on the sample at t = 1
// cfg     | in  | cfg_valid/cfg_ready/cfg_data   | points_per_segment (N)
//
// An item occupies the input side from the transfer through the prep state that forms the
// Horner coefficients, then while the issue counter gives one sample per cycle if out does
// not stall. Samples leave a 7-stage pipeline (three multiply stages, each followed by an
// add stage, then rounding) one per cycle likewise. A cfg write starts a bit-serial division
// 2^16 / N for the t step; input is held off meanwhile. Reset is synchronous; no clearing
// pass is needed. An out stall freezes the whole pipeline; nothing is lost or repeated.
module cubic_hermite_curve_sampler_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // start_x, start_y, start_z, start_handle_x, start_handle_y, start_handle_z,
  // end_handle_x, end_handle_y, end_handle_z, end_x, end_y, end_z
  input  logic [chcs_pkg::IN_W-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // curve_x, curve_y, curve_z
  output logic [chcs_pkg::OUT_W-1:0]     out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [chcs_pkg::STEP_W-1:0]    cfg_data
);

  import chcs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PREP  = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;

  localparam int NSTG = 7;

  // ---------------------------------------------------------------------------------------
  // Step count register and reciprocal divider
  // ---------------------------------------------------------------------------------------
  logic [STEP_W-1:0]    steps_r;
  logic [STEP_W-1:0]    n_eff;
  logic                 div_busy_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [STEP_W-1:0]    div_rem_r;
  tval_t                div_q_r;
  logic [STEP_W:0]      div_sh;
  logic                 div_ge;
  logic [1:0]           state_r;

  // zero steps acts as one, too many clamps
  always_comb begin
    priority if (steps_r == '0) begin
      n_eff = STEP_W'(1);
    end else if (steps_r > STEP_W'(MAX_STEPS)) begin
      n_eff = STEP_W'(MAX_STEPS);
    end else begin
      n_eff = steps_r;
    end
  end

  assign cfg_ready = (state_r == ST_IDLE) && !div_busy_r;

  // dividend is 2^T_FRAC_BITS: the only set bit is the first one shifted in
  assign div_sh = {div_rem_r, (div_cnt_r == '0)};
  assign div_ge = div_sh >= {1'b0, n_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r    <= STEP_W'(STEP_RESET);
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      div_rem_r  <= R_RESET;
      div_q_r    <= Q_RESET;
    end else if (cfg_valid && cfg_ready) begin
      steps_r    <= cfg_data;
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
      div_rem_r  <= '0;
      div_q_r    <= '0;
    end else if (div_busy_r) begin
      div_rem_r <= div_ge ? STEP_W'(div_sh - {1'b0, n_eff}) : div_sh[STEP_W-1:0];
      div_q_r   <= {div_q_r[TW-2:0], div_ge};
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      if (div_cnt_r == DIV_CNT_W'(TW - 1)) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Item capture, coefficient prep and sample issue
  // ---------------------------------------------------------------------------------------
  coord_t                 p1_r [NUM_AXES];
  coord_t                 p4_r [NUM_AXES];
  logic signed [DW-1:0]   d1_r [NUM_AXES];
  logic signed [DW-1:0]   d4_r [NUM_AXES];
  logic signed [C3W-1:0]  c3_r [NUM_AXES];
  logic signed [C2W-1:0]  c2_r [NUM_AXES];

  tval_t             t_r;
  logic [STEP_W-1:0] frac_r;
  logic [STEP_W-1:0] idx_r;
  logic [STEP_W:0]   frac_sum;
  logic              frac_carry;
  logic              issue_last;
  logic              adv;
  logic              issue;
  logic              in_acc;
  logic [NSTG-1:0]   vld_r;

  assign in_tready  = (state_r == ST_IDLE) && !div_busy_r && !cfg_valid;
  assign in_acc     = in_tvalid && in_tready;
  assign adv        = !vld_r[NSTG-1] || out_tready;
  assign issue      = (state_r == ST_ISSUE) && adv;
  assign issue_last = (idx_r == n_eff);

  // t_i = i*q + floor(i*r/N), with q, r the quotient and remainder of 2^16 / N
  assign frac_sum   = {1'b0, frac_r} + {1'b0, div_rem_r};
  assign frac_carry = frac_sum >= {1'b0, n_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      t_r     <= '0;
      frac_r  <= '0;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_r <= ST_ISSUE;
          t_r     <= '0;
          frac_r  <= '0;
          idx_r   <= '0;
        end
        ST_ISSUE: begin
          if (issue) begin
            t_r    <= t_r + div_q_r + tval_t'(frac_carry);
            frac_r <= frac_carry ? STEP_W'(frac_sum - {1'b0, n_eff}) : frac_sum[STEP_W-1:0];
            idx_r  <= idx_r + STEP_W'(1);
            if (issue_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // held geometry and Horner coefficients (doubled curve)
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        p1_r[ax] <= $signed(in_tdata[ax * COORD_WIDTH +: COORD_WIDTH]);
        p4_r[ax] <= $signed(in_tdata[(9 + ax) * COORD_WIDTH +: COORD_WIDTH]);
        d1_r[ax] <= DW'($signed(in_tdata[(3 + ax) * COORD_WIDTH +: COORD_WIDTH]))
                  - DW'($signed(in_tdata[ax * COORD_WIDTH +: COORD_WIDTH]));
        d4_r[ax] <= DW'($signed(in_tdata[(6 + ax) * COORD_WIDTH +: COORD_WIDTH]))
                  - DW'($signed(in_tdata[(9 + ax) * COORD_WIDTH +: COORD_WIDTH]));
      end
    end
    if (state_r == ST_PREP) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        // c3 = 4P1 - 4P4 + D1 + D4
        c3_r[ax] <= (C3W'(p1_r[ax]) <<< 2) - (C3W'(p4_r[ax]) <<< 2)
                  + C3W'(d1_r[ax]) + C3W'(d4_r[ax]);
        // c2 = -6P1 + 6P4 - 2D1 - D4
        c2_r[ax] <= (C2W'(p4_r[ax]) <<< 2) + (C2W'(p4_r[ax]) <<< 1)
                  - (C2W'(p1_r[ax]) <<< 2) - (C2W'(p1_r[ax]) <<< 1)
                  - (C2W'(d1_r[ax]) <<< 1) - C2W'(d4_r[ax]);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Evaluation pipeline
  // ---------------------------------------------------------------------------------------
  tval_t                 s1_t, s2_t, s3_t, s4_t;
  logic                  s1_last, s2_last, s3_last, s4_last, s5_last, s6_last, last_r;
  logic signed [PRW-1:0] s1_pr [NUM_AXES];
  logic signed [C2W-1:0] s1_c2 [NUM_AXES];
  logic signed [DW-1:0]  s1_d1 [NUM_AXES];
  logic signed [DW-1:0]  s2_d1 [NUM_AXES];
  logic signed [DW-1:0]  s3_d1 [NUM_AXES];
  coord_t                s1_p1 [NUM_AXES];
  coord_t                s2_p1 [NUM_AXES];
  coord_t                s3_p1 [NUM_AXES];
  coord_t                s4_p1 [NUM_AXES];
  coord_t                s5_p1 [NUM_AXES];
  logic signed [B1W-1:0] s2_b1 [NUM_AXES];
  logic signed [M2W-1:0] s3_m2 [NUM_AXES];
  logic signed [A2W-1:0] s4_a2 [NUM_AXES];
  logic signed [M3W-1:0] s5_m3 [NUM_AXES];
  logic signed [A3W-1:0] s6_a3 [NUM_AXES];
  logic signed [RW-1:0]  rnd   [NUM_AXES];
  coord_t                sat   [NUM_AXES];
  coord_t                coord_r [NUM_AXES];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], issue};
    end
  end

  // round to nearest (halves up) and saturate
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      rnd[ax] = RW'((s6_a3[ax] + (A3W'(1) <<< GUARD_BITS)) >>> (GUARD_BITS + 1));
      if (rnd[ax] > SAT_HI) begin
        sat[ax] = SAT_HI[COORD_WIDTH-1:0];
      end else if (rnd[ax] < SAT_LO) begin
        sat[ax] = SAT_LO[COORD_WIDTH-1:0];
      end else begin
        sat[ax] = rnd[ax][COORD_WIDTH-1:0];
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t    <= t_r;
      s1_last <= issue_last;
      s2_t    <= s1_t;
      s2_last <= s1_last;
      s3_t    <= s2_t;
      s3_last <= s2_last;
      s4_t    <= s3_t;
      s4_last <= s3_last;
      s5_last <= s4_last;
      s6_last <= s5_last;
      last_r  <= s6_last;
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        // c3 * t
        s1_pr[ax] <= c3_r[ax] * $signed({1'b0, t_r});
        s1_c2[ax] <= c2_r[ax];
        s1_d1[ax] <= d1_r[ax];
        s1_p1[ax] <= p1_r[ax];
        // first Horner step, kept at guard / 2^8 scale
        s2_b1[ax] <= (B1W'(s1_c2[ax]) <<< T_FRAC_BITS) + B1W'(s1_pr[ax]);
        s2_d1[ax] <= s1_d1[ax];
        s2_p1[ax] <= s1_p1[ax];
        // b1 * t
        s3_m2[ax] <= s2_b1[ax] * $signed({1'b0, s2_t});
        s3_d1[ax] <= s2_d1[ax];
        s3_p1[ax] <= s2_p1[ax];
        // second Horner step
        s4_a2[ax] <= (A2W'(s3_d1[ax]) <<< GUARD_BITS)
                   + A2W'(s3_m2[ax] >>> (T_FRAC_BITS - (GUARD_BITS - T_FRAC_BITS)));
        s4_p1[ax] <= s3_p1[ax];
        // a2 * t
        s5_m3[ax] <= s4_a2[ax] * $signed({1'b0, s4_t});
        s5_p1[ax] <= s4_p1[ax];
        // doubled curve
        s6_a3[ax] <= (A3W'(s5_p1[ax]) <<< (GUARD_BITS + 1))
                   + A3W'(s5_m3[ax] >>> T_FRAC_BITS);
        coord_r[ax] <= sat[ax];
      end
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {coord_r[2], coord_r[1], coord_r[0]};
  assign out_tlast  = last_r;

`ifndef NO_ASSERTIONS
  a_last_t_one: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && issue_last) |-> (t_r == T_ONE))
    else $error("last sample issued with t other than one");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ISSUE) |-> (frac_r < n_eff))
    else $error("t step remainder out of range");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy_r |-> (!in_tready && (state_r == ST_IDLE)))
    else $error("item taken or issued while step divider busy");
`endif

endmodule
